FILE: src/uer_pkg.sv
`timescale 1ns / 1ps

package uer_pkg;

  // Register reset values
  localparam logic [7:0]  TRIG_HIGH_RST = 8'd10;
  localparam logic [15:0] TIMEOUT_RST   = 16'd30000;
  localparam logic [9:0]  MAX_DIST_RST  = 10'd400;

  // Register indexes (word address = 4 * index)
  localparam logic [1:0] REG_TRIG_HIGH = 2'd0;
  localparam logic [1:0] REG_TIMEOUT   = 2'd1;
  localparam logic [1:0] REG_MAX_DIST  = 2'd2;

  // Trigger is held low for this many ticks before going high
  localparam logic [15:0] LOW_TICKS    = 16'd2;
  localparam logic [9:0]  FAIL_CM      = 10'd999;
  localparam logic [9:0]  CLAMP_LIMIT  = 10'd998;

  // width / 58 = (width >> 1) / 29; (x * 18079) >> 19 is exact for x < 2^15
  localparam logic [14:0] RECIP_29     = 15'd18079;
  localparam int          RECIP_SHIFT  = 19;

  typedef struct packed {
    logic [7:0]  trigger_high_ticks;
    logic [15:0] timeout_ticks;
    logic [9:0]  max_distance_cm;
  } cfg_t;

  typedef enum logic [4:0] {
    PH_IDLE      = 5'b00001,
    PH_TRIG_LOW  = 5'b00010,
    PH_TRIG_HIGH = 5'b00100,
    PH_WAIT_RISE = 5'b01000,
    PH_MEASURE   = 5'b10000
  } phase_t;

  typedef struct packed {
    logic       sensor_failed;
    logic [9:0] distance_cm;
    logic       done_res;
    logic       trigger_level;
  } result_t;

endpackage

FILE: src/ultrasonic_echo_ranger.sv
`timescale 1ns / 1ps

// Ultrasonic echo ranger. One input word is one 1 us tick: start_req and the
// sampled echo_level. Every tick word yields exactly one output word with the
// trigger pin level for that tick and, on the tick a measurement ends, done,
// the distance in cm (clamped to max_distance_cm, 998 at most) or 999 with
// sensor_failed on a timeout or zero-width pulse.
// Channels: s_* takes tick words, m_* gives result words, APB port holds the
// three registers (trigger high ticks at 0x0, timeout at 0x4, clamp at 0x8).
// A word accepted into the input register is processed when it advances and is
// stored in the output register, from which m_* shows it.
// Throughput: one word per cycle while m_tready stays high. An input register feeds one pass of the
// phase machine plus the /58 reciprocal multiply into the output register.
// Reset clears the phase machine, counters and the valid flags of both pipeline registers and
// loads the register defaults (10, 30000, 400).
// When m_tready is low the result holds in the output register; a word is
// still taken into the input register only if it is empty, and s_tready stays
// low while it holds a word until the receiver takes the result.
module ultrasonic_echo_ranger (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] start_req, [1] echo_level, rest zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [0] trigger_level, [1] done_res,
                                 // [11:2] distance_cm, [12] sensor_failed
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  uer_pkg::cfg_t    cfg;
  uer_pkg::result_t res_comb;
  uer_pkg::result_t res;

  logic in_vld;
  logic in_start;
  logic in_echo;
  logic adv;

  uer_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The held word advances when the output register is free or being drained
  assign adv      = in_vld & (~m_tvalid | m_tready);
  assign s_tready = ~in_vld | adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tready) begin
      in_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_start <= s_tdata[0];
      in_echo  <= s_tdata[1];
    end
  end

  uer_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .step       (adv),
    .start_req  (in_start),
    .echo_level (in_echo),
    .result     (res_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res <= res_comb;
    end
  end

  assign m_tdata = {3'd0, res};

  // Failure always reports the fixed failure distance with done
  a_fail_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res.sensor_failed |-> res.done_res && res.distance_cm == uer_pkg::FAIL_CM)
    else $error("failure result without done or failure distance");

  // Ticks without a finished measurement carry no distance
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !res.done_res |-> res.distance_cm == 10'd0 && !res.sensor_failed)
    else $error("distance or failure on a tick without done");

  // A good measurement stays within the clamp
  a_clamp: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res.done_res && !res.sensor_failed |-> res.distance_cm <= uer_pkg::CLAMP_LIMIT)
    else $error("distance above clamp limit");

  // Trigger is never high on the tick a measurement ends
  a_trig_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res.done_res |-> !res.trigger_level)
    else $error("trigger high on a done tick");

  // A processed word always lands in the output register
  a_adv_out: assert property (@(posedge clk) disable iff (rst)
    adv |=> m_tvalid)
    else $error("processed word lost");

endmodule

FILE: src/uer_regs.sv
`timescale 1ns / 1ps

module uer_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output uer_pkg::cfg_t      cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trigger_high_ticks <= uer_pkg::TRIG_HIGH_RST;
      cfg.timeout_ticks      <= uer_pkg::TIMEOUT_RST;
      cfg.max_distance_cm    <= uer_pkg::MAX_DIST_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        uer_pkg::REG_TRIG_HIGH: cfg.trigger_high_ticks <= pwdata[7:0];
        uer_pkg::REG_TIMEOUT:   cfg.timeout_ticks      <= pwdata[15:0];
        uer_pkg::REG_MAX_DIST:  cfg.max_distance_cm    <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      uer_pkg::REG_TRIG_HIGH: prdata = {24'd0, cfg.trigger_high_ticks};
      uer_pkg::REG_TIMEOUT:   prdata = {16'd0, cfg.timeout_ticks};
      uer_pkg::REG_MAX_DIST:  prdata = {22'd0, cfg.max_distance_cm};
      default:                prdata = 32'd0;
    endcase
  end

endmodule

FILE: src/uer_core.sv
`timescale 1ns / 1ps

module uer_core (
  input  logic               clk,
  input  logic               rst,
  input  uer_pkg::cfg_t      cfg,
  input  logic               step,
  input  logic               start_req,
  input  logic               echo_level,
  output uer_pkg::result_t   result
);

  uer_pkg::phase_t phase, phase_next;
  logic [15:0] tick_count, tick_count_next;
  logic [15:0] pulse_width, pulse_width_next;

  logic [15:0] tick_inc;
  logic [15:0] pw_inc;
  logic [29:0] prod;
  logic [10:0] quot;
  logic [9:0]  lim;
  logic [9:0]  dist_ok;
  logic        finish;
  logic        fail;

  assign tick_inc = tick_count + 16'd1;
  assign pw_inc   = pulse_width + 16'd1;

  // Distance from the width held so far (used when echo falls)
  assign prod    = pulse_width[15:1] * uer_pkg::RECIP_29;
  assign quot    = prod[29:uer_pkg::RECIP_SHIFT];
  assign lim     = (cfg.max_distance_cm > uer_pkg::CLAMP_LIMIT) ? uer_pkg::CLAMP_LIMIT
                                                                : cfg.max_distance_cm;
  assign dist_ok = ({1'b0, lim} < quot) ? lim : quot[9:0];

  always_comb begin
    phase_next       = phase;
    tick_count_next  = tick_count;
    pulse_width_next = pulse_width;
    finish           = 1'b0;
    fail             = 1'b0;
    result           = '0;
    case (phase)
      uer_pkg::PH_IDLE: begin
        if (start_req) begin
          phase_next       = uer_pkg::PH_TRIG_LOW;
          tick_count_next  = 16'd1;
          pulse_width_next = 16'd0;
        end
      end
      uer_pkg::PH_TRIG_LOW: begin
        tick_count_next = tick_inc;
        if (tick_inc >= uer_pkg::LOW_TICKS) begin
          phase_next      = uer_pkg::PH_TRIG_HIGH;
          tick_count_next = 16'd0;
        end
      end
      uer_pkg::PH_TRIG_HIGH: begin
        result.trigger_level = 1'b1;
        tick_count_next      = tick_inc;
        if (tick_inc >= {8'd0, cfg.trigger_high_ticks}) begin
          phase_next      = uer_pkg::PH_WAIT_RISE;
          tick_count_next = 16'd0;
        end
      end
      uer_pkg::PH_WAIT_RISE: begin
        if (echo_level) begin
          phase_next       = uer_pkg::PH_MEASURE;
          pulse_width_next = 16'd1;
          if (cfg.timeout_ticks <= 16'd1) begin
            finish = 1'b1;
            fail   = 1'b1;
          end
        end else begin
          tick_count_next = tick_inc;
          if (tick_inc >= cfg.timeout_ticks) begin
            finish = 1'b1;
            fail   = 1'b1;
          end
        end
      end
      uer_pkg::PH_MEASURE: begin
        if (echo_level) begin
          pulse_width_next = pw_inc;
          if (pw_inc >= cfg.timeout_ticks) begin
            finish = 1'b1;
            fail   = 1'b1;
          end
        end else begin
          finish = 1'b1;
          fail   = (pulse_width == 16'd0);
        end
      end
      default: begin
        phase_next      = uer_pkg::PH_IDLE;
        tick_count_next = 16'd0;
      end
    endcase

    if (finish) begin
      phase_next           = uer_pkg::PH_IDLE;
      tick_count_next      = 16'd0;
      result.done_res      = 1'b1;
      result.sensor_failed = fail;
      result.distance_cm   = fail ? uer_pkg::FAIL_CM : dist_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= uer_pkg::PH_IDLE;
      tick_count  <= 16'd0;
      pulse_width <= 16'd0;
    end else if (step) begin
      phase       <= phase_next;
      tick_count  <= tick_count_next;
      pulse_width <= pulse_width_next;
    end
  end

endmodule
